// ===== rtl/dsch_pkg.sv =====
package dsch_pkg;

	// Configuration register indexes
	localparam logic [7:0] CFG_MODE           = 8'd0;
	localparam logic [7:0] CFG_HEAD_START     = 8'd1;
	localparam logic [7:0] CFG_HEAD_PREVIOUS  = 8'd2;
	localparam logic [7:0] CFG_CYLINDER_COUNT = 8'd3;

	// Scheduling modes
	localparam logic [1:0] MODE_FCFS  = 2'd0;
	localparam logic [1:0] MODE_SSTF  = 2'd1;
	localparam logic [1:0] MODE_SCAN  = 2'd2;
	localparam logic [1:0] MODE_CSCAN = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY,
		ST_SSTF_SCAN,
		ST_SWAP1,
		ST_SWAP2,
		ST_SEL,
		ST_SEL_WRITE,
		ST_DIST,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/dsch_ram.sv =====
module dsch_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/disk_request_scheduler.sv =====
// Channel   Direction  Transfer condition        Payload
// request   in         start & !busy             request_cylinder, final_request
// result    out        visit_valid (one cycle)   visit_cylinder, seek_total, final_visit
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// The final request starts scheduling: FCFS copies the batch; SSTF copies,
// then runs one scan per slot plus a swap (SWAP1, SWAP2); SCAN/C-SCAN pick
// each slot by a full scan of the store; then a distance pass and the emit
// pass follow.
// Reset clears the request count, the served marks and the configuration
// registers; the request RAM needs no clearing. The result receiver cannot
// stall: each visited cylinder shows for exactly one cycle, and busy stays
// high until the last one has gone.
module disk_request_scheduler
	import dsch_pkg::*;
#(
	parameter int MAX_REQUESTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        request_cylinder,
	input  logic               final_request,
	output logic               visit_valid,
	output logic [15:0]        visit_cylinder,
	output logic signed [22:0] seek_total,
	output logic               final_visit,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int QW = $clog2(MAX_REQUESTS + 1);
	localparam int SW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam logic [QW-1:0] MAXN = QW'(MAX_REQUESTS);

	state_t state_q, state_d;

	logic [1:0]  mode_q;
	logic [15:0] head_start_q, head_previous_q, cylinder_count_q;

	logic [QW-1:0] cnt_q, n_q, n_d, p_q;
	logic [QW-1:0] rd_q, end_q, idx_s1, scan_lo, scan_hi, best_idx_q;
	logic          ing_q, vld_s1, have_q;
	logic [MAX_REQUESTS-1:0] marks_q;

	logic [15:0] best_val_q, best_d_q, first_val_q, cur_q, prev_q;
	logic signed [22:0] dist_q;

	logic accept, room, scan_done, start_scan, up_first, second_smaller;

	logic          st_we;
	logic [15:0]   st_rdata;
	logic          sq_we;
	logic [QW-1:0] sq_waddr;
	logic [15:0]   sq_wdata, sq_rdata;

	logic [15:0] sstf_d;
	logic        sstf_take, sel_take;

	function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign room      = (cnt_q != MAXN);
	assign scan_done = vld_s1 && (idx_s1 == end_q);

	// SCAN direction: upward first when the head moved up; C-SCAN always up
	assign up_first       = (mode_q == MODE_CSCAN) || (head_start_q > head_previous_q);
	assign second_smaller = (mode_q == MODE_CSCAN) || !up_first;

	function automatic logic in_first(input logic [15:0] v, input logic up,
			input logic [15:0] hs);
		return up ? (v >= hs) : (v <= hs);
	endfunction

	// Candidate a beats b: first sweep before second, then by sweep direction
	function automatic logic better(input logic [15:0] a, input logic [15:0] b,
			input logic up, input logic sec_small, input logic [15:0] hs);
		logic fa, fb;
		fa = in_first(a, up, hs);
		fb = in_first(b, up, hs);
		if (fa != fb) return fa;
		if (fa) return up ? (a < b) : (a > b);
		return sec_small ? (a < b) : (a > b);
	endfunction

	dsch_ram #(.WIDTH(16), .DEPTH(MAX_REQUESTS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (cnt_q[SW-1:0]),
		.wdata (request_cylinder),
		.raddr (rd_q[SW-1:0]),
		.rdata (st_rdata)
	);

	dsch_ram #(.WIDTH(16), .DEPTH(MAX_REQUESTS + 1)) u_seq (
		.clk   (clk),
		.we    (sq_we),
		.waddr (sq_waddr),
		.wdata (sq_wdata),
		.raddr (rd_q),
		.rdata (sq_rdata)
	);

	assign st_we = accept && room;

	assign sstf_d    = abs_diff(sq_rdata, cur_q);
	assign sstf_take = (idx_s1 == p_q + QW'(1)) || (sstf_d < best_d_q);
	assign sel_take  = !marks_q[idx_s1[SW-1:0]] &&
		(!have_q || better(st_rdata, best_val_q, up_first, second_smaller, head_start_q));

	// Next state, scan bounds and sequence RAM writes
	always_comb begin
		state_d  = state_q;
		n_d      = n_q;
		scan_lo  = '0;
		scan_hi  = n_q;
		sq_we    = 1'b0;
		sq_waddr = '0;
		sq_wdata = head_start_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && final_request) begin
					n_d      = cnt_q + QW'(room);
					sq_we    = 1'b1;
					state_d  = (mode_q == MODE_FCFS || mode_q == MODE_SSTF) ? ST_COPY : ST_SEL;
				end
			end
			ST_COPY: begin
				sq_we    = vld_s1;
				sq_waddr = idx_s1 + QW'(1);
				sq_wdata = st_rdata;
				if (scan_done) begin
					state_d = (mode_q == MODE_SSTF && n_q > QW'(1)) ? ST_SSTF_SCAN : ST_DIST;
				end
			end
			ST_SSTF_SCAN: begin
				if (scan_done) state_d = ST_SWAP1;
			end
			ST_SWAP1: begin
				sq_we    = 1'b1;
				sq_waddr = best_idx_q;
				sq_wdata = first_val_q;
				state_d  = ST_SWAP2;
			end
			ST_SWAP2: begin
				sq_we    = 1'b1;
				sq_waddr = p_q + QW'(1);
				sq_wdata = best_val_q;
				state_d  = ({1'b0, p_q} + (QW+1)'(2) < {1'b0, n_q}) ? ST_SSTF_SCAN : ST_DIST;
			end
			ST_SEL: begin
				if (scan_done) state_d = ST_SEL_WRITE;
			end
			ST_SEL_WRITE: begin
				sq_we    = 1'b1;
				sq_waddr = p_q + QW'(1);
				sq_wdata = best_val_q;
				state_d  = (p_q + QW'(1) == n_q) ? ST_DIST : ST_SEL;
			end
			ST_DIST: begin
				if (scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (scan_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase

		unique case (state_d)
			ST_COPY: begin
				scan_lo = '0;
				scan_hi = n_d - QW'(1);
			end
			ST_SSTF_SCAN: begin
				scan_lo = (state_q == ST_SWAP2) ? p_q + QW'(2) : QW'(1);
				scan_hi = n_d;
			end
			ST_SEL: begin
				scan_lo = '0;
				scan_hi = n_d - QW'(1);
			end
			default: begin
				scan_lo = '0;
				scan_hi = n_d;
			end
		endcase
	end

	assign start_scan = (state_d != state_q) &&
		(state_d == ST_COPY || state_d == ST_SSTF_SCAN || state_d == ST_SEL ||
		 state_d == ST_DIST || state_d == ST_EMIT);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			mode_q           <= MODE_FCFS;
			head_start_q     <= '0;
			head_previous_q  <= '0;
			cylinder_count_q <= '0;
			cnt_q            <= '0;
			marks_q          <= '0;
			ing_q            <= 1'b0;
			vld_s1           <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MODE:           mode_q           <= cfg_data[1:0];
					CFG_HEAD_START:     head_start_q     <= cfg_data;
					CFG_HEAD_PREVIOUS:  head_previous_q  <= cfg_data;
					CFG_CYLINDER_COUNT: cylinder_count_q <= cfg_data;
					default: ;
				endcase
			end
			if (st_we) cnt_q <= cnt_q + QW'(1);
			// Issue one read a cycle across the scan window
			if (start_scan) begin
				ing_q <= 1'b1;
			end else if (ing_q && rd_q == end_q) begin
				ing_q <= 1'b0;
			end
			vld_s1 <= ing_q && !start_scan;
			if (state_q == ST_SEL_WRITE) marks_q[best_idx_q[SW-1:0]] <= 1'b1;
			// Drop the batch after the last visit has gone out
			if (state_q == ST_EMIT && scan_done) begin
				cnt_q   <= '0;
				marks_q <= '0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		n_q    <= n_d;
		idx_s1 <= rd_q;
		if (start_scan) begin
			rd_q  <= scan_lo;
			end_q <= scan_hi;
		end else if (ing_q) begin
			rd_q <= rd_q + QW'(1);
		end

		unique case (state_q)
			ST_IDLE: begin
				p_q    <= '0;
				cur_q  <= head_start_q;
				have_q <= 1'b0;
			end
			ST_SSTF_SCAN: begin
				if (vld_s1 && sstf_take) begin
					best_d_q   <= sstf_d;
					best_val_q <= sq_rdata;
					best_idx_q <= idx_s1;
				end
				if (vld_s1 && idx_s1 == p_q + QW'(1)) first_val_q <= sq_rdata;
			end
			ST_SWAP2: begin
				cur_q <= best_val_q;
				p_q   <= p_q + QW'(1);
			end
			ST_SEL: begin
				if (vld_s1 && sel_take) begin
					best_val_q <= st_rdata;
					best_idx_q <= idx_s1;
					have_q     <= 1'b1;
				end
			end
			ST_SEL_WRITE: begin
				p_q    <= p_q + QW'(1);
				have_q <= 1'b0;
			end
			ST_DIST: begin
				if (vld_s1) begin
					prev_q <= sq_rdata;
					// C-SCAN: cylinders minus (start minus last visited)
					if (scan_done && mode_q == MODE_CSCAN) begin
						dist_q <= 23'(cylinder_count_q) - 23'(head_start_q) + 23'(sq_rdata);
					end else if (idx_s1 == '0) begin
						dist_q <= '0;
					end else begin
						dist_q <= dist_q + 23'(abs_diff(sq_rdata, prev_q));
					end
				end
			end
			default: ;
		endcase
	end

	assign visit_valid    = (state_q == ST_EMIT) && vld_s1;
	assign visit_cylinder = sq_rdata;
	assign seek_total     = dist_q;
	assign final_visit    = visit_valid && (idx_s1 == n_q);

	a_visit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		visit_valid |-> busy) else $error("visit outside a schedule");

	a_final_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		final_visit |-> visit_valid) else $error("final mark without strobe");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(visit_valid && final_visit) |=> !busy) else $error("busy after last visit");

	a_batch_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && final_request) |=> busy) else $error("batch did not start");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAXN) else $error("request count beyond store");

endmodule

// ===== test/disk_request_scheduler_checker.sv =====
`timescale 1ns / 1ps

module disk_request_scheduler_checker
	import dsch_pkg::*;
#(
	parameter int MAX_REQUESTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [15:0]        request_cylinder,
	input  logic               final_request,
	input  logic               visit_valid,
	input  logic [15:0]        visit_cylinder,
	input  logic signed [22:0] seek_total,
	input  logic               final_visit,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		logic [15:0]        cyl;
		logic signed [22:0] seek;
		logic               last;
	} visit_t;

	visit_t      visit_queue[$];
	logic [1:0]  sched_mode;
	logic [15:0] head_pos, head_prev, cyl_total;
	logic [15:0] batch[MAX_REQUESTS];
	int          batch_len;

	assign pending = visit_queue.size();

	// Build the visit order of the stored batch and queue one entry per visit.
	function automatic void schedule_batch();
		logic [15:0] order[$];
		logic [15:0] asc[$];
		logic [15:0] t;
		int          best, bd, d, seek_sum;
		visit_t      v;
		order.push_back(head_pos);
		if (sched_mode == MODE_FCFS || sched_mode == MODE_SSTF) begin
			for (int i = 0; i < batch_len; i++)
				order.push_back(batch[i]);
			if (sched_mode == MODE_SSTF) begin
				for (int p = 0; p + 1 < batch_len; p++) begin
					best = p + 1;
					bd = (order[p+1] > order[p]) ? order[p+1] - order[p] : order[p] - order[p+1];
					for (int j = p + 2; j <= batch_len; j++) begin
						d = (order[j] > order[p]) ? order[j] - order[p] : order[p] - order[j];
						if (d < bd) begin
							bd = d;
							best = j;
						end
					end
					t = order[p+1];
					order[p+1] = order[best];
					order[best] = t;
				end
			end
		end else begin
			for (int i = 0; i < batch_len; i++)
				asc.push_back(batch[i]);
			asc.sort();
			if (sched_mode == MODE_CSCAN || head_pos > head_prev) begin
				foreach (asc[i]) if (asc[i] >= head_pos) order.push_back(asc[i]);
				if (sched_mode == MODE_CSCAN) begin
					foreach (asc[i]) if (asc[i] < head_pos) order.push_back(asc[i]);
				end else begin
					for (int i = batch_len - 1; i >= 0; i--)
						if (asc[i] < head_pos) order.push_back(asc[i]);
				end
			end else begin
				for (int i = batch_len - 1; i >= 0; i--)
					if (asc[i] <= head_pos) order.push_back(asc[i]);
				foreach (asc[i]) if (asc[i] > head_pos) order.push_back(asc[i]);
			end
		end
		seek_sum = 0;
		if (sched_mode == MODE_CSCAN)
			seek_sum = int'(cyl_total) - (int'(head_pos) - int'(order[batch_len]));
		else
			for (int i = 0; i < batch_len; i++)
				seek_sum += (order[i+1] > order[i]) ? order[i+1] - order[i] : order[i] - order[i+1];
		foreach (order[i]) begin
			v.cyl = order[i];
			v.seek = seek_sum[22:0];
			v.last = (i == batch_len);
			visit_queue.push_back(v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		visit_t exp_v;
		if (!arst_n) begin
			sched_mode <= MODE_FCFS;
			head_pos <= '0;
			head_prev <= '0;
			cyl_total <= '0;
			batch_len = 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: sched_mode <= cfg_data[1:0];
					CFG_HEAD_START: head_pos <= cfg_data;
					CFG_HEAD_PREVIOUS: head_prev <= cfg_data;
					CFG_CYLINDER_COUNT: cyl_total <= cfg_data;
					default: ;
				endcase
			end
			// Compare the result against the oldest queued visit.
			if (visit_valid) begin
				if (visit_queue.size() == 0) begin
					$error("unexpected visit: visit_cylinder %0d", visit_cylinder);
					fail_count <= fail_count + 1;
				end else begin
					exp_v = visit_queue.pop_front();
					if (visit_cylinder !== exp_v.cyl || seek_total !== exp_v.seek ||
						final_visit !== exp_v.last)
						fail_count <= fail_count + 1;
					if (visit_cylinder !== exp_v.cyl)
						$error("visit_cylinder expected %0d actual %0d", exp_v.cyl, visit_cylinder);
					if (seek_total !== exp_v.seek)
						$error("seek_total expected %0d actual %0d", exp_v.seek, seek_total);
					if (final_visit !== exp_v.last)
						$error("final_visit expected %0b actual %0b", exp_v.last, final_visit);
				end
			end
			// Store the request, drop it when full; a final one closes the batch.
			if (start && !busy) begin
				if (batch_len < MAX_REQUESTS) begin
					batch[batch_len] = request_cylinder;
					batch_len++;
				end
				if (final_request) begin
					schedule_batch();
					batch_len = 0;
				end
			end
		end
	end

endmodule

// ===== test/disk_request_scheduler_tb.sv =====
`timescale 1ns / 1ps

module disk_request_scheduler_tb
	import dsch_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [15:0]        request_cylinder;
	logic               final_request;
	logic               visit_valid;
	logic [15:0]        visit_cylinder;
	logic signed [22:0] seek_total;
	logic               final_visit;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         cfg_index;
	logic [15:0]        cfg_data;
	int                 fail_count;
	int                 pending;
	int                 stall_cycles;
	int                 request_total;
	bit                 gaps_on;
	logic [15:0]        head_now;

	disk_request_scheduler DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request_cylinder(request_cylinder), .final_request(final_request),
		.visit_valid(visit_valid), .visit_cylinder(visit_cylinder),
		.seek_total(seek_total), .final_visit(final_visit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	disk_request_scheduler_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request_cylinder(request_cylinder), .final_request(final_request),
		.visit_valid(visit_valid), .visit_cylinder(visit_cylinder),
		.seek_total(seek_total), .final_visit(final_visit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count cycles without any transfer; give up when the block hangs.
	always @(posedge clk) begin
		if ((start && !busy) || visit_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Now and then hold start low for a random gap before a request.
	task automatic maybe_idle();
		if (gaps_on && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(9, 1)) @(posedge clk);
		end
	endtask

	// Write one register; the caller guarantees the block is idle.
	task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
		bit hit;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_HEAD_START)
			head_now = value;
		do begin
			@(negedge clk);
			hit = cfg_ready;
			@(posedge clk);
		end while (!hit);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [1:0] m, input logic [15:0] head,
		input logic [15:0] prev, input logic [15:0] cyls);
		write_reg(CFG_MODE, {14'd0, m});
		write_reg(CFG_HEAD_START, head);
		write_reg(CFG_HEAD_PREVIOUS, prev);
		write_reg(CFG_CYLINDER_COUNT, cyls);
	endtask

	// Transfer one request; hold start until the block takes it.
	task automatic send_request(input logic [15:0] cyl, input logic last);
		bit hit;
		maybe_idle();
		start <= 1'b1;
		request_cylinder <= cyl;
		final_request <= last;
		do begin
			@(negedge clk);
			hit = !busy;
			@(posedge clk);
		end while (!hit);
		request_total++;
	endtask

	// Drop start and wait until every visit of the batch has come out.
	task automatic drain();
		bit idle;
		start <= 1'b0;
		do begin
			@(negedge clk);
			idle = (pending == 0) && !busy;
			@(posedge clk);
		end while (!idle);
	endtask

	task automatic send_batch(input logic [15:0] cyls[$]);
		foreach (cyls[i])
			send_request(cyls[i], i == cyls.size() - 1);
		drain();
	endtask

	// Random batch: uniform, clustered near the head, or full of duplicates.
	task automatic random_batch(input int n);
		logic [15:0] cyls[$];
		int          kind;
		logic [15:0] pick[3];
		kind = $urandom_range(2);
		pick[0] = 16'd0;
		pick[1] = 16'hFFFF;
		pick[2] = head_now;
		for (int i = 0; i < n; i++) begin
			case (kind)
				0: cyls.push_back(16'($urandom));
				1: cyls.push_back(head_now + 16'($urandom_range(40)) - 16'd20);
				default: cyls.push_back(pick[$urandom_range(2)]);
			endcase
		end
		send_batch(cyls);
	endtask

	function automatic logic [15:0] rand_cyl();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int nb;
		arst_n <= 1'b0;
		start <= 1'b0;
		request_cylinder <= '0;
		final_request <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		request_total = 0;
		gaps_on = 1'b1;
		head_now = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Arrival order with the cylinder extremes.
		set_config(MODE_FCFS, 16'd100, 16'd50, 16'd200);
		send_batch('{16'd0, 16'hFFFF, 16'd100});
		// Shortest seek with a tie; the earlier request must win.
		set_config(MODE_SSTF, 16'd50, 16'd0, 16'd0);
		send_batch('{16'd40, 16'd60, 16'd55, 16'd45});
		// Elevator sweeping up first, a request sitting on the head.
		set_config(MODE_SCAN, 16'd100, 16'd50, 16'd0);
		send_batch('{16'd100, 16'd20, 16'd150, 16'hFFFF, 16'd0});
		// Head equal to previous head sweeps down first.
		write_reg(CFG_HEAD_PREVIOUS, 16'd100);
		send_batch('{16'd100, 16'd101, 16'd99});
		// One-way sweep with zero cylinders: the distance goes negative.
		set_config(MODE_CSCAN, 16'd500, 16'd0, 16'd0);
		send_batch('{16'd600, 16'd10, 16'd499, 16'd500});
		// An index past the register list must be ignored.
		write_reg(8'd7, 16'hFFFF);
		write_reg(8'hFF, 16'h1234);
		set_config(MODE_CSCAN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_batch('{16'hFFFF});

		// Random batches; one overfills the store so late requests drop.
		nb = 0;
		while (request_total < 165) begin
			if (request_total > 135)
				gaps_on = 1'b0;
			set_config(2'($urandom), rand_cyl(), rand_cyl(), rand_cyl());
			if ($urandom_range(4) == 0)
				write_reg(8'($urandom_range(255, 4)), 16'($urandom));
			if (nb == 5)
				random_batch(34);
			else if (nb == 12)
				random_batch(32);
			else
				random_batch($urandom_range(8, 1));
			nb++;
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dsch_pkg.sv
rtl/dsch_ram.sv
rtl/disk_request_scheduler.sv
test/disk_request_scheduler_checker.sv
test/disk_request_scheduler_tb.sv
